/* src/assert_macros.svh */
// assertion macros shared by the containment unit rtl
// no dependencies; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/pcr_pkg.sv */
// shared codes and interface types of the polygon containment unit
// no dependencies; used by pcr_edge_eval and the top level
`default_nettype none

package pcr_pkg;

   // request kinds
   localparam logic [2:0] KIND_CLEAR    = 3'd0;
   localparam logic [2:0] KIND_APPEND   = 3'd1;
   localparam logic [2:0] KIND_POINT    = 3'd2;
   localparam logic [2:0] KIND_RECT_HIT = 3'd3;
   localparam logic [2:0] KIND_RECT_IN  = 3'd4;

   // product steps of the edge unit (even steps pair with the first term)
   localparam logic [2:0] STEP_Q0  = 3'd0;
   localparam logic [2:0] STEP_Q1  = 3'd1;
   localparam logic [2:0] STEP_LO0 = 3'd2;
   localparam logic [2:0] STEP_LO1 = 3'd3;
   localparam logic [2:0] STEP_HI0 = 3'd4;
   localparam logic [2:0] STEP_HI1 = 3'd5;

   typedef struct packed {
      logic start;
      logic rect;
   } edge_cmd_type;

   typedef struct packed {
      logic              done;
      logic              cut;
      logic signed [2:0] delta;
   } edge_res_type;

endpackage

`default_nettype wire

/* src/pcr_vertex_mem.sv */
// vertex store: one write port, one read port with registered data
// no dependencies; instanced by the containment unit top level
`default_nettype none

module pcr_vertex_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // synchronous write and read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/pcr_edge_eval.sv */
// one polygon edge against a query point or rectangle, exact intercepts
// depends on pcr_pkg and assert_macros.svh; one shared multiplier
`default_nettype none
`include "assert_macros.svh"

module pcr_edge_eval #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pcr_pkg::edge_cmd_type        cmd,
   input  wire logic signed [COORD_BITS:0]   q_rx0,
   input  wire logic signed [COORD_BITS:0]   q_ry0,
   input  wire logic signed [COORD_BITS:0]   q_rx1,
   input  wire logic signed [COORD_BITS:0]   q_ry1,
   input  wire logic signed [COORD_BITS-1:0] x0,
   input  wire logic signed [COORD_BITS-1:0] y0,
   input  wire logic signed [COORD_BITS-1:0] x1,
   input  wire logic signed [COORD_BITS-1:0] y1,
   output pcr_pkg::edge_res_type             res
);

   localparam int OW = COORD_BITS + 2;
   localparam int PW = 2 * OW;
   localparam int SW = PW + 1;
   localparam logic signed [OW-1:0] OneC      = OW'(1);
   localparam logic signed [2:0]    DeltaUp   = 3'sd1;
   localparam logic signed [2:0]    DeltaDown = -3'sd1;

   typedef enum logic [4:0] {
      E_IDLE  = 5'b00001,
      E_CLASS = 5'b00010,
      E_MUL   = 5'b00100,
      E_ACC   = 5'b01000,
      E_JUDGE = 5'b10000
   } edge_state_type;

   edge_state_type         state_ff, state_in;
   logic [2:0]             step_ff, step_in;
   pcr_pkg::edge_res_type  res_ff, res_in;
   logic                   load_ops;

   logic                   rect_ff;
   logic signed [OW-1:0]   rx0_ff, ry0_ff, rx1_ff, ry1_ff;
   logic signed [OW-1:0]   ex0_ff, ey0_ff, ex1_ff, ey1_ff;
   logic signed [OW-1:0]   a0_ff, a1_ff, bx_ff, nbx_ff, d0_ff, d1_ff;
   logic signed [OW-1:0]   pl0_ff, pl1_ff, ph0_ff, ph1_ff;
   logic                   d0neg_ff, d1neg_ff;
   logic signed [PW-1:0]   prod_ff, q0_ff, q1_ff;
   logic [1:0]             pos_ff, neg_ff;

   logic                   up, skip_p, left_p, skip_r, shadow_r, inside_r;
   logic signed [2:0]      dir_delta, sh_delta;
   logic signed [OW-1:0]   dy, a0c, a1c, d0c, d1c;
   logic signed [OW-1:0]   ma, mb;
   logic signed [PW-1:0]   qsel;
   logic signed [SW-1:0]   sum;
   logic                   s_neg, s_pos, dneg, pos_adj, neg_adj;

   // edge classification against the query
   always_comb begin
      up        = ey0_ff < ey1_ff;
      dir_delta = up ? DeltaUp : DeltaDown;
      skip_p    = (ry0_ff < ey0_ff && ry0_ff < ey1_ff) ||
                  (ry0_ff >= ey0_ff && ry0_ff >= ey1_ff) ||
                  (rx0_ff >= ex0_ff && rx0_ff >= ex1_ff);
      left_p    = rx0_ff < ex0_ff && rx0_ff < ex1_ff;
      skip_r    = (ey0_ff >= ry1_ff && ey1_ff >= ry1_ff) ||
                  (ey0_ff <= ry0_ff && ey1_ff <= ry0_ff) ||
                  (ex0_ff <= rx0_ff && ex1_ff <= rx0_ff);
      shadow_r  = ex0_ff >= rx1_ff && ex1_ff >= rx1_ff;
      inside_r  = (ex0_ff > rx0_ff && ex0_ff < rx1_ff && ey0_ff > ry0_ff && ey0_ff < ry1_ff) ||
                  (ex1_ff > rx0_ff && ex1_ff < rx1_ff && ey1_ff > ry0_ff && ey1_ff < ry1_ff);
      sh_delta  = 3'sd0;
      if (up) begin
         if (ey0_ff <= ry0_ff) sh_delta = sh_delta + DeltaUp;
         if (ey1_ff >= ry1_ff) sh_delta = sh_delta + DeltaUp;
      end else if (ey1_ff < ey0_ff) begin
         if (ey1_ff <= ry0_ff) sh_delta = sh_delta + DeltaDown;
         if (ey0_ff >= ry1_ff) sh_delta = sh_delta + DeltaDown;
      end
      dy = ey1_ff - ey0_ff;
      if (!rect_ff) begin
         a0c = ry0_ff - ey0_ff;
      end else if (ey0_ff < ry0_ff) begin
         a0c = ry0_ff - ey0_ff;
      end else if (ey0_ff > ry1_ff) begin
         a0c = ry1_ff - ey0_ff;
      end else begin
         a0c = '0;
      end
      if (ey1_ff < ry0_ff) begin
         a1c = ry0_ff - ey1_ff;
      end else if (ey1_ff > ry1_ff) begin
         a1c = ry1_ff - ey1_ff;
      end else begin
         a1c = '0;
      end
      d0c = (!rect_ff || (a0c != '0 && dy != '0)) ? dy : OneC;
      d1c = (a1c != '0 && dy != '0) ? (ey0_ff - ey1_ff) : OneC;
   end

   // multiplier operand selection
   always_comb begin
      case (step_ff)
         pcr_pkg::STEP_Q0:  begin ma = a0_ff;  mb = bx_ff;  end
         pcr_pkg::STEP_Q1:  begin ma = a1_ff;  mb = nbx_ff; end
         pcr_pkg::STEP_LO0: begin ma = pl0_ff; mb = d0_ff;  end
         pcr_pkg::STEP_LO1: begin ma = pl1_ff; mb = d1_ff;  end
         pcr_pkg::STEP_HI0: begin ma = ph0_ff; mb = d0_ff;  end
         pcr_pkg::STEP_HI1: begin ma = ph1_ff; mb = d1_ff;  end
         default:           begin ma = '0;     mb = '0;     end
      endcase
   end

   // sign of the cross-multiplied intercept, turned by the divisor sign
   always_comb begin
      qsel    = step_ff[0] ? q1_ff : q0_ff;
      sum     = SW'(prod_ff) + SW'(qsel);
      s_neg   = sum[SW-1];
      s_pos   = !s_neg && (sum != '0);
      dneg    = step_ff[0] ? d1neg_ff : d0neg_ff;
      pos_adj = dneg ? s_neg : s_pos;
      neg_adj = dneg ? s_pos : s_neg;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      res_in   = '0;
      load_ops = 1'b0;
      case (state_ff)
         E_IDLE: begin
            if (cmd.start) state_in = E_CLASS;
         end
         E_CLASS: begin
            state_in = E_IDLE;
            if (rect_ff) begin
               if (skip_r) begin
                  res_in.done = 1'b1;
               end else if (shadow_r) begin
                  res_in.done  = 1'b1;
                  res_in.delta = sh_delta;
               end else if (inside_r) begin
                  res_in.done = 1'b1;
                  res_in.cut  = 1'b1;
               end else begin
                  load_ops = 1'b1;
                  step_in  = pcr_pkg::STEP_Q0;
                  state_in = E_MUL;
               end
            end else begin
               if (skip_p) begin
                  res_in.done = 1'b1;
               end else if (left_p) begin
                  res_in.done  = 1'b1;
                  res_in.delta = dir_delta;
               end else begin
                  load_ops = 1'b1;
                  step_in  = pcr_pkg::STEP_Q0;
                  state_in = E_MUL;
               end
            end
         end
         E_MUL: begin
            state_in = E_ACC;
         end
         E_ACC: begin
            state_in = E_MUL;
            case (step_ff)
               pcr_pkg::STEP_Q0: begin
                  step_in = rect_ff ? pcr_pkg::STEP_Q1 : pcr_pkg::STEP_LO0;
               end
               pcr_pkg::STEP_Q1:  step_in = pcr_pkg::STEP_LO0;
               pcr_pkg::STEP_LO0: begin
                  if (rect_ff) begin
                     step_in = pcr_pkg::STEP_LO1;
                  end else begin
                     res_in.done  = 1'b1;
                     res_in.delta = pos_adj ? dir_delta : 3'sd0;
                     state_in     = E_IDLE;
                  end
               end
               pcr_pkg::STEP_LO1: state_in = E_JUDGE;
               pcr_pkg::STEP_HI0: step_in = pcr_pkg::STEP_HI1;
               pcr_pkg::STEP_HI1: state_in = E_JUDGE;
               default:           state_in = E_IDLE;
            endcase
         end
         E_JUDGE: begin
            state_in = E_IDLE;
            if (step_ff == pcr_pkg::STEP_LO1) begin
               if (!pos_ff[0] && !pos_ff[1]) begin
                  res_in.done = 1'b1;
               end else begin
                  step_in  = pcr_pkg::STEP_HI0;
                  state_in = E_MUL;
               end
            end else if (!neg_ff[0] && !neg_ff[1]) begin
               res_in.done  = 1'b1;
               res_in.delta = sh_delta;
            end else begin
               res_in.done = 1'b1;
               res_in.cut  = 1'b1;
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         step_ff  <= pcr_pkg::STEP_Q0;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         res_ff   <= res_in;
      end
   end

   // operand, product and sign registers
   always_ff @(posedge clock) begin
      if (state_ff == E_IDLE && cmd.start) begin
         rect_ff <= cmd.rect;
         rx0_ff  <= OW'(q_rx0);
         ry0_ff  <= OW'(q_ry0);
         rx1_ff  <= OW'(q_rx1);
         ry1_ff  <= OW'(q_ry1);
         ex0_ff  <= OW'(x0);
         ey0_ff  <= OW'(y0);
         ex1_ff  <= OW'(x1);
         ey1_ff  <= OW'(y1);
      end
      if (load_ops) begin
         a0_ff    <= a0c;
         a1_ff    <= a1c;
         d0_ff    <= d0c;
         d1_ff    <= d1c;
         d0neg_ff <= d0c[OW-1];
         d1neg_ff <= d1c[OW-1];
         bx_ff    <= ex1_ff - ex0_ff;
         nbx_ff   <= ex0_ff - ex1_ff;
         pl0_ff   <= ex0_ff - rx0_ff;
         pl1_ff   <= ex1_ff - rx0_ff;
         ph0_ff   <= ex0_ff - rx1_ff;
         ph1_ff   <= ex1_ff - rx1_ff;
      end
      if (state_ff == E_MUL) begin
         prod_ff <= PW'(ma) * PW'(mb);
      end
      if (state_ff == E_ACC) begin
         if (step_ff == pcr_pkg::STEP_Q0) q0_ff <= prod_ff;
         if (step_ff == pcr_pkg::STEP_Q1) q1_ff <= prod_ff;
         if (step_ff != pcr_pkg::STEP_Q0 && step_ff != pcr_pkg::STEP_Q1) begin
            pos_ff[step_ff[0]] <= pos_adj;
            neg_ff[step_ff[0]] <= neg_adj;
         end
      end
   end

   assign res = res_ff;

   // checks
   `ASSERT_IMPL(a_start_when_idle, clock, reset, cmd.start, state_ff == E_IDLE)
   `ASSERT_IMPL(a_cut_carries_no_count, clock, reset, res_ff.done && res_ff.cut, res_ff.delta == 3'sd0)
   `ASSERT_IMPL(a_point_never_cuts, clock, reset, res_ff.done && !rect_ff, !res_ff.cut)

endmodule

`default_nettype wire

/* src/polygon_point_rect_containment_unit.sv */
// polygon point and rectangle containment unit; uses pcr_pkg, pcr_vertex_mem, pcr_edge_eval
// clear, append and unused kinds: result loaded in the finish state once output is free
// queries walk the n stored vertices; an edge takes a memory fetch, a load and a pass
// through the edge unit with its single shared multiplier
// one request in work at a time; a finished result waits in the output register
// synchronous reset empties the store, zeroes the bounds and selects even-odd
`default_nettype none
`include "assert_macros.svh"

module polygon_point_rect_containment_unit #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [2:0]                            req_kind,
   input  wire logic signed [COORD_BITS-1:0]          req_coord_x,
   input  wire logic signed [COORD_BITS-1:0]          req_coord_y,
   input  wire logic signed [COORD_BITS-1:0]          req_rect_width,
   input  wire logic signed [COORD_BITS-1:0]          req_rect_height,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_answer,
   output logic [$clog2(MAX_VERTICES+1)-1:0]          rsp_vertex_total,
   output logic                                       rsp_status,
   input  wire logic                                  csr_write_enable,
   input  wire logic                                  csr_write_data
);

   localparam int W   = COORD_BITS;
   localparam int W1  = COORD_BITS + 1;
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int AW  = $clog2(MAX_VERTICES);
   localparam int CRW = $clog2(MAX_VERTICES) + 4;

   typedef enum logic [7:0] {
      T_IDLE   = 8'b00000001,
      T_CHECK  = 8'b00000010,
      T_FETCH  = 8'b00000100,
      T_LOAD   = 8'b00001000,
      T_EDGE   = 8'b00010000,
      T_CLOSE  = 8'b00100000,
      T_TALLY  = 8'b01000000,
      T_FINISH = 8'b10000000
   } top_state_type;

   top_state_type          state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic signed [W-1:0]    min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic signed [W-1:0]    max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic [CW-1:0]          idx_ff, idx_in, idx_next;
   logic signed [CRW-1:0]  cr_ff, cr_in;
   logic                   cut_ff, cut_in, closing_ff, closing_in;
   logic                   ans_ff, ans_in, status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_load;
   logic                   rsp_answer_ff, rsp_status_ff;
   logic [CW-1:0]          rsp_total_ff;
   logic                   wind_ff;

   logic [2:0]             kind_ff;
   logic signed [W-1:0]    qx_ff, qy_ff;
   logic signed [W1-1:0]   rx1_ff, ry1_ff;
   logic                   size_bad_ff;
   logic signed [W-1:0]    v0x_ff, v0y_ff, prevx_ff, prevy_ff, curx_ff, cury_ff;

   logic                   mem_wr_en;
   logic [2*W-1:0]         mem_rd_data;
   logic signed [W-1:0]    rd_x, rd_y;
   logic signed [W-1:0]    edge_x1, edge_y1;
   pcr_pkg::edge_cmd_type  edge_cmd;
   pcr_pkg::edge_res_type  edge_res;
   logic                   accept, full, is_point, pt_ok, rect_ok, close_need, hit;

   assign accept   = req_valid && req_ready;
   assign full     = count_ff >= CW'(MAX_VERTICES);
   assign is_point = kind_ff == pcr_pkg::KIND_POINT;
   assign idx_next = idx_ff + CW'(1);
   assign rd_x     = mem_rd_data[W-1:0];
   assign rd_y     = mem_rd_data[2*W-1:W];

   // vertex store
   pcr_vertex_mem #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (2 * W),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_coord_y, req_coord_x}),
      .rd_en   (state_ff == T_FETCH),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   // edge unit, closing edge ends at the first vertex
   assign edge_x1 = (state_ff == T_LOAD) ? rd_x : v0x_ff;
   assign edge_y1 = (state_ff == T_LOAD) ? rd_y : v0y_ff;

   pcr_edge_eval #(
      .COORD_BITS (COORD_BITS)
   ) u_edge (
      .clock (clock),
      .reset (reset),
      .cmd   (edge_cmd),
      .q_rx0 (W1'(qx_ff)),
      .q_ry0 (W1'(qy_ff)),
      .q_rx1 (rx1_ff),
      .q_ry1 (ry1_ff),
      .x0    (prevx_ff),
      .y0    (prevy_ff),
      .x1    (edge_x1),
      .y1    (edge_y1),
      .res   (edge_res)
   );

   // bounds pre-tests, closing edge test and final rule
   always_comb begin
      pt_ok = count_ff > CW'(2) && qx_ff >= min_x_ff && qy_ff >= min_y_ff &&
              qx_ff < max_x_ff && qy_ff < max_y_ff;
      rect_ok = count_ff != '0 && max_x_ff > min_x_ff && max_y_ff > min_y_ff &&
                !size_bad_ff && rx1_ff > W1'(min_x_ff) && ry1_ff > W1'(min_y_ff) &&
                qx_ff < max_x_ff && qy_ff < max_y_ff;
      close_need = is_point ? (prevy_ff != v0y_ff)
                            : (prevx_ff != v0x_ff || prevy_ff != v0y_ff);
      hit = wind_ff ? (is_point ? cr_ff[0] : cr_ff[1]) : (cr_ff != '0);
   end

   // main sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      min_x_in   = min_x_ff;
      min_y_in   = min_y_ff;
      max_x_in   = max_x_ff;
      max_y_in   = max_y_ff;
      idx_in     = idx_ff;
      cr_in      = cr_ff;
      cut_in     = cut_ff;
      closing_in = closing_ff;
      ans_in     = ans_ff;
      status_in  = status_ff;
      mem_wr_en  = 1'b0;
      rsp_load   = 1'b0;
      edge_cmd.start = 1'b0;
      edge_cmd.rect  = !is_point;
      case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               ans_in    = 1'b0;
               status_in = 1'b0;
               state_in  = T_FINISH;
               case (req_kind)
                  pcr_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     min_x_in = '0;
                     min_y_in = '0;
                     max_x_in = '0;
                     max_y_in = '0;
                  end
                  pcr_pkg::KIND_APPEND: begin
                     if (full) begin
                        status_in = 1'b1;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                        if (count_ff == '0) begin
                           min_x_in = req_coord_x;
                           max_x_in = req_coord_x;
                           min_y_in = req_coord_y;
                           max_y_in = req_coord_y;
                        end else begin
                           if (req_coord_x < min_x_ff) min_x_in = req_coord_x;
                           if (req_coord_x > max_x_ff) max_x_in = req_coord_x;
                           if (req_coord_y < min_y_ff) min_y_in = req_coord_y;
                           if (req_coord_y > max_y_ff) max_y_in = req_coord_y;
                        end
                     end
                  end
                  pcr_pkg::KIND_POINT, pcr_pkg::KIND_RECT_HIT, pcr_pkg::KIND_RECT_IN: begin
                     state_in = T_CHECK;
                  end
                  default: state_in = T_FINISH;
               endcase
            end
         end
         T_CHECK: begin
            if (is_point ? pt_ok : rect_ok) begin
               idx_in     = '0;
               cr_in      = '0;
               cut_in     = 1'b0;
               closing_in = 1'b0;
               state_in   = T_FETCH;
            end else begin
               ans_in   = 1'b0;
               state_in = T_FINISH;
            end
         end
         T_FETCH: state_in = T_LOAD;
         T_LOAD: begin
            if (idx_ff == '0) begin
               idx_in   = CW'(1);
               state_in = (count_ff > CW'(1)) ? T_FETCH : T_CLOSE;
            end else begin
               edge_cmd.start = 1'b1;
               state_in       = T_EDGE;
            end
         end
         T_EDGE: begin
            if (edge_res.done) begin
               cr_in  = cr_ff + CRW'(edge_res.delta);
               cut_in = cut_ff | edge_res.cut;
               if (closing_ff || edge_res.cut) begin
                  state_in = T_TALLY;
               end else begin
                  idx_in   = idx_next;
                  state_in = (idx_next < count_ff) ? T_FETCH : T_CLOSE;
               end
            end
         end
         T_CLOSE: begin
            if (close_need) begin
               edge_cmd.start = 1'b1;
               closing_in     = 1'b1;
               state_in       = T_EDGE;
            end else begin
               state_in = T_TALLY;
            end
         end
         T_TALLY: begin
            if (is_point) begin
               ans_in = hit;
            end else if (kind_ff == pcr_pkg::KIND_RECT_IN) begin
               ans_in = !cut_ff && hit;
            end else begin
               ans_in = cut_ff || hit;
            end
            state_in = T_FINISH;
         end
         T_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         count_ff     <= '0;
         min_x_ff     <= '0;
         min_y_ff     <= '0;
         max_x_ff     <= '0;
         max_y_ff     <= '0;
         idx_ff       <= '0;
         cr_ff        <= '0;
         cut_ff       <= 1'b0;
         closing_ff   <= 1'b0;
         ans_ff       <= 1'b0;
         status_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wind_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_x_ff     <= min_x_in;
         min_y_ff     <= min_y_in;
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         idx_ff       <= idx_in;
         cr_ff        <= cr_in;
         cut_ff       <= cut_in;
         closing_ff   <= closing_in;
         ans_ff       <= ans_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) wind_ff <= csr_write_data;
      end
   end

   // request capture, walk registers and result register
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_kind;
         qx_ff       <= req_coord_x;
         qy_ff       <= req_coord_y;
         rx1_ff      <= W1'(req_coord_x) + W1'(req_rect_width);
         ry1_ff      <= W1'(req_coord_y) + W1'(req_rect_height);
         size_bad_ff <= req_rect_width[W-1] || req_rect_width == '0 ||
                        req_rect_height[W-1] || req_rect_height == '0;
      end
      if (state_ff == T_LOAD) begin
         if (idx_ff == '0) begin
            v0x_ff   <= rd_x;
            v0y_ff   <= rd_y;
            prevx_ff <= rd_x;
            prevy_ff <= rd_y;
         end else begin
            curx_ff <= rd_x;
            cury_ff <= rd_y;
         end
      end
      if (state_ff == T_EDGE && edge_res.done && !closing_ff) begin
         prevx_ff <= curx_ff;
         prevy_ff <= cury_ff;
      end
      if (rsp_load) begin
         rsp_answer_ff <= ans_ff;
         rsp_total_ff  <= count_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign req_ready        = state_ff == T_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_answer       = rsp_answer_ff;
   assign rsp_vertex_total = rsp_total_ff;
   assign rsp_status       = rsp_status_ff;

   // checks
   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_VERTICES))
   `ASSERT_NEXT(a_one_request_in_work, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPL(a_rsp_from_finish, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff), $past(state_ff == T_FINISH))
   `ASSERT_IMPL(a_walk_in_range, clock, reset, state_ff == T_FETCH, idx_ff < count_ff)

endmodule

`default_nettype wire
